[rtl/core/im2col_pkg.sv]
// ----------------------------------------------------------------------------
// im2col_pkg
// Shared types, register indexes and helpers for the im2col descriptor core.
// ----------------------------------------------------------------------------
package im2col_pkg;

  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 16;
  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 96;
  localparam int OUT_TUSER_W = 1;
  localparam int SRC_OFF_W   = 36;
  localparam int DST_OFF_W   = 32;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SRC_HEIGHT    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SRC_WIDTH     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SRC_CHANNELS  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_KERNEL_DIMS   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_STRIDE_PAIR   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_DILATION_PAIR = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_PAD_PAIR      = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_PITCH     = 3'd7;

  typedef struct packed {
    logic [12:0] src_height;
    logic [12:0] src_width;
    logic [12:0] src_channels;
    logic [5:0]  kernel_dims;
    logic [7:0]  stride_pair;
    logic [7:0]  dilation_pair;
    logic [7:0]  pad_pair;
    logic [15:0] row_pitch;
  } cfg_t;

  // one tap handed from the sequencer to the datapath
  typedef struct packed {
    logic       vld;
    logic [2:0] ky;
    logic [2:0] kx;
    logic [5:0] tap;
    logic       last;
  } issue_t;

  // kernel side minus one, limited to the supported side minus one
  function automatic logic [2:0] clamp_side_m1(input logic [2:0] f,
                                               input logic [2:0] lim_m1);
    clamp_side_m1 = (f > lim_m1) ? lim_m1 : f;
  endfunction

endpackage

[rtl/core/im2col_cfg.sv]
// ----------------------------------------------------------------------------
// im2col_cfg
// Configuration register file, write-only.
// ----------------------------------------------------------------------------
module im2col_cfg (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_wr_en,
  input  logic [im2col_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [im2col_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output im2col_pkg::cfg_t               cfg
);
  import im2col_pkg::*;

  cfg_t cfg_r, cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr_en) begin
      case (cfg_index)
        REG_SRC_HEIGHT:    cfg_nxt.src_height    = cfg_wdata[12:0];
        REG_SRC_WIDTH:     cfg_nxt.src_width     = cfg_wdata[12:0];
        REG_SRC_CHANNELS:  cfg_nxt.src_channels  = cfg_wdata[12:0];
        REG_KERNEL_DIMS:   cfg_nxt.kernel_dims   = cfg_wdata[5:0];
        REG_STRIDE_PAIR:   cfg_nxt.stride_pair   = cfg_wdata[7:0];
        REG_DILATION_PAIR: cfg_nxt.dilation_pair = cfg_wdata[7:0];
        REG_PAD_PAIR:      cfg_nxt.pad_pair      = cfg_wdata[7:0];
        REG_ROW_PITCH:     cfg_nxt.row_pitch     = cfg_wdata[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.src_height    <= 13'd1;
      cfg_r.src_width     <= 13'd1;
      cfg_r.src_channels  <= 13'd1;
      cfg_r.kernel_dims   <= 6'd0;
      cfg_r.stride_pair   <= 8'd0;
      cfg_r.dilation_pair <= 8'd0;
      cfg_r.pad_pair      <= 8'd0;
      cfg_r.row_pitch     <= 16'd1;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

[rtl/core/im2col_ctrl.sv]
// ----------------------------------------------------------------------------
// im2col_ctrl
// Tap sequencer: takes a pixel, then walks ky/kx one tap per advance.
// ----------------------------------------------------------------------------
module im2col_ctrl #(
  parameter int MAX_KERNEL_SIDE = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  input  im2col_pkg::cfg_t   cfg,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  logic               adv,
  output im2col_pkg::issue_t issue
);
  import im2col_pkg::*;

  localparam logic [2:0] SIDE_LIM_M1 = 3'(MAX_KERNEL_SIDE - 1);
  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_RUN  = 1'b1;

  logic       state_r, state_nxt;
  logic [2:0] ky_r, ky_nxt;
  logic [2:0] kx_r, kx_nxt;
  logic [5:0] tap_r, tap_nxt;
  logic [2:0] kh_m1, kw_m1;
  logic       row_end, last_tap;

  assign kh_m1    = clamp_side_m1(cfg.kernel_dims[5:3], SIDE_LIM_M1);
  assign kw_m1    = clamp_side_m1(cfg.kernel_dims[2:0], SIDE_LIM_M1);
  assign row_end  = (kx_r == kw_m1);
  assign last_tap = row_end && (ky_r == kh_m1);

  assign in_tready  = (state_r == ST_IDLE);
  assign issue.vld  = (state_r == ST_RUN) && adv;
  assign issue.ky   = ky_r;
  assign issue.kx   = kx_r;
  assign issue.tap  = tap_r;
  assign issue.last = last_tap;

  always_comb begin
    state_nxt = state_r;
    ky_nxt    = ky_r;
    kx_nxt    = kx_r;
    tap_nxt   = tap_r;
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          state_nxt = ST_RUN;
          ky_nxt    = 3'd0;
          kx_nxt    = 3'd0;
          tap_nxt   = 6'd0;
        end
      end
      ST_RUN: begin
        if (adv) begin
          tap_nxt = tap_r + 6'd1;
          if (row_end) begin
            kx_nxt = 3'd0;
            ky_nxt = ky_r + 3'd1;
          end else begin
            kx_nxt = kx_r + 3'd1;
          end
          if (last_tap) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      ky_r    <= 3'd0;
      kx_r    <= 3'd0;
      tap_r   <= 6'd0;
    end else begin
      state_r <= state_nxt;
      ky_r    <= ky_nxt;
      kx_r    <= kx_nxt;
      tap_r   <= tap_nxt;
    end
  end

  // last tap issued returns the sequencer to idle
  a_last_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
    issue.vld && issue.last |=> state_r == ST_IDLE)
    else $error("sequencer did not return to idle after last tap");

  // a stall freezes the tap walk
  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_RUN && !adv |=> state_r == ST_RUN && $stable(tap_r))
    else $error("tap counter moved during stall");

endmodule

[rtl/core/im2col_dp.sv]
// ----------------------------------------------------------------------------
// im2col_dp
// Offset datapath: four compute stages plus the output register.
// ----------------------------------------------------------------------------
module im2col_dp #(
  parameter int MAX_KERNEL_SIDE = 8,
  parameter int COORD_BITS      = 12
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  im2col_pkg::cfg_t                      cfg,
  input  logic                                  in_accept,
  input  logic [im2col_pkg::IN_TDATA_W-1:0]     in_tdata,
  input  im2col_pkg::issue_t                    issue,
  output logic                                  adv,
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  output logic [im2col_pkg::OUT_TDATA_W-1:0]    out_tdata,
  output logic [im2col_pkg::OUT_TUSER_W-1:0]    out_tuser,
  output logic                                  out_tlast
);
  import im2col_pkg::*;

  localparam int CB    = (COORD_BITS < 12) ? COORD_BITS : 12;
  localparam int PS_W  = CB + 5;                  // out coord times stride
  localparam int SY_W  = CB + 6;                  // signed source coord
  localparam int CMP_W = (SY_W > 14) ? SY_W : 14;
  localparam logic [2:0] SIDE_LIM_M1 = 3'(MAX_KERNEL_SIDE - 1);

  // ---- per-pixel terms, captured on accept ----
  logic [CB-1:0]    oy_c, ox_c;
  logic [4:0]       sh, sw, dh, dw;
  logic [3:0]       pt, pl;
  logic [2:0]       kh_m1, kw_m1;
  logic [6:0]       taps;
  logic [19:0]      patch;
  logic [15:0]      gap_c;
  logic [PS_W-1:0]  oys_r, oxs_r;
  logic [31:0]      base_r;
  logic [15:0]      gap_r;

  assign oy_c  = CB'(in_tdata[11:0]);
  assign ox_c  = CB'(in_tdata[23:12]);
  assign sh    = {1'b0, cfg.stride_pair[7:4]} + 5'd1;
  assign sw    = {1'b0, cfg.stride_pair[3:0]} + 5'd1;
  assign dh    = {1'b0, cfg.dilation_pair[7:4]} + 5'd1;
  assign dw    = {1'b0, cfg.dilation_pair[3:0]} + 5'd1;
  assign pt    = cfg.pad_pair[7:4];
  assign pl    = cfg.pad_pair[3:0];
  assign kh_m1 = clamp_side_m1(cfg.kernel_dims[5:3], SIDE_LIM_M1);
  assign kw_m1 = clamp_side_m1(cfg.kernel_dims[2:0], SIDE_LIM_M1);
  assign taps  = 7'(({4'd0, kh_m1} + 7'd1) * ({4'd0, kw_m1} + 7'd1));
  assign patch = 20'(taps) * 20'(cfg.src_channels);
  assign gap_c = ({4'd0, cfg.row_pitch} > patch) ?
                 16'({4'd0, cfg.row_pitch} - patch) : 16'd0;

  always_ff @(posedge clk) begin
    if (in_accept) begin
      oys_r  <= PS_W'(oy_c) * PS_W'(sh);
      oxs_r  <= PS_W'(ox_c) * PS_W'(sw);
      base_r <= 32'(in_tdata[39:24]) * 32'(cfg.row_pitch);
      gap_r  <= gap_c;
    end
  end

  // ---- stage 1: source coords, raw dest offset ----
  logic [7:0]              kyd, kxd;
  logic [18:0]             tapc;
  logic signed [SY_W-1:0]  sy_c, sx_c;
  logic                    v1_r;
  logic signed [SY_W-1:0]  sy1_r, sx1_r;
  logic [32:0]             doff1_r;
  logic [5:0]              tap1_r;
  logic                    last1_r;

  assign kyd  = 8'(issue.ky) * 8'(dh);
  assign kxd  = 8'(issue.kx) * 8'(dw);
  assign tapc = 19'(issue.tap) * 19'(cfg.src_channels);
  assign sy_c = $signed({1'b0, oys_r}) + $signed(SY_W'(kyd)) - $signed(SY_W'(pt));
  assign sx_c = $signed({1'b0, oxs_r}) + $signed(SY_W'(kxd)) - $signed(SY_W'(pl));

  // ---- stage 2: padding test, row product ----
  logic        pad_c;
  logic        v2_r, pad2_r, last2_r;
  logic [25:0] prod2_r;
  logic [12:0] sx2_r;
  logic [31:0] doff2_r;
  logic [5:0]  tap2_r;

  assign pad_c = sy1_r[SY_W-1] || sx1_r[SY_W-1] ||
                 (CMP_W'($unsigned(sy1_r)) >= CMP_W'(cfg.src_height)) ||
                 (CMP_W'($unsigned(sx1_r)) >= CMP_W'(cfg.src_width));

  // ---- stage 3: pixel index ----
  logic        v3_r, pad3_r, last3_r;
  logic [26:0] lin3_r;
  logic [31:0] doff3_r;
  logic [5:0]  tap3_r;

  // ---- stage 4: element offset ----
  logic        v4_r, pad4_r, last4_r;
  logic [39:0] soff4_r;
  logic [31:0] doff4_r;
  logic [5:0]  tap4_r;

  // ---- output register ----
  logic                 out_vld_r;
  logic [5:0]           tap_o_r;
  logic [SRC_OFF_W-1:0] src_o_r;
  logic [DST_OFF_W-1:0] dst_o_r;
  logic [15:0]          gap_o_r;
  logic                 zf_o_r, last_o_r;
  logic [SRC_OFF_W-1:0] src_sat;

  assign adv     = !out_vld_r || out_tready;
  assign src_sat = pad4_r ? '0 : ((|soff4_r[39:36]) ? '1 : soff4_r[35:0]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r      <= 1'b0;
      v2_r      <= 1'b0;
      v3_r      <= 1'b0;
      v4_r      <= 1'b0;
      out_vld_r <= 1'b0;
    end else if (adv) begin
      v1_r      <= issue.vld;
      v2_r      <= v1_r;
      v3_r      <= v2_r;
      v4_r      <= v3_r;
      out_vld_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sy1_r   <= sy_c;
      sx1_r   <= sx_c;
      doff1_r <= 33'(base_r) + 33'(tapc);
      tap1_r  <= issue.tap;
      last1_r <= issue.last;

      pad2_r  <= pad_c;
      prod2_r <= 26'(13'($unsigned(sy1_r))) * 26'(cfg.src_width);
      sx2_r   <= 13'($unsigned(sx1_r));
      doff2_r <= doff1_r[32] ? '1 : doff1_r[31:0];
      tap2_r  <= tap1_r;
      last2_r <= last1_r;

      pad3_r  <= pad2_r;
      lin3_r  <= 27'(prod2_r) + 27'(sx2_r);
      doff3_r <= doff2_r;
      tap3_r  <= tap2_r;
      last3_r <= last2_r;

      pad4_r  <= pad3_r;
      soff4_r <= 40'(lin3_r) * 40'(cfg.src_channels);
      doff4_r <= doff3_r;
      tap4_r  <= tap3_r;
      last4_r <= last3_r;

      tap_o_r  <= tap4_r;
      src_o_r  <= src_sat;
      dst_o_r  <= doff4_r;
      gap_o_r  <= last4_r ? gap_r : 16'd0;
      zf_o_r   <= pad4_r;
      last_o_r <= last4_r;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {6'd0, gap_o_r, dst_o_r, src_o_r, tap_o_r};
  assign out_tuser  = zf_o_r;
  assign out_tlast  = last_o_r;

  a_gap_only_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && !last_o_r |-> gap_o_r == 16'd0)
    else $error("gap count on a non-final descriptor");

  a_pad_src_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && zf_o_r |-> src_o_r == '0)
    else $error("padding descriptor with nonzero source offset");

endmodule

[rtl/core/im2col_patch_descriptor_gen_core.sv]
// ----------------------------------------------------------------------------
// im2col_patch_descriptor_gen_core
// im2col address generator for NHWC 16-bit images: one copy descriptor per
// kernel tap of each convolution output pixel.
// ----------------------------------------------------------------------------
//
//  channel | dir | handshake           | payload
//  --------+-----+---------------------+-----------------------------------
//  cfg     | in  | cfg_wr_en           | cfg_index (reg 0..7), cfg_wdata
//  in      | in  | in_tvalid/in_tready | in_tdata: out_y, out_x, row_index
//  out     | out | out_tvalid/tready   | out_tdata, out_tuser, out_tlast
//
//  A pixel takes one beat to accept, then the tap sequencer issues one tap
//  per cycle while the output is not stalled (1..64 descriptors per pixel).
//  Each descriptor passes through 4 compute stages and the output register
//  after its tap is issued; the next pixel is taken while the pipe drains.
//  rst_n is synchronous; it empties the pipe and loads register defaults.
//  out_tready low with a descriptor waiting stalls the sequencer and every
//  pipe stage together.
//
module im2col_patch_descriptor_gen_core #(
  parameter int MAX_KERNEL_SIDE = 8,
  parameter int COORD_BITS      = 12
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  // configuration
  input  logic                                  cfg_wr_en,
  input  logic [im2col_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [im2col_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  // pixel input
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  // [11:0] out_y, [23:12] out_x, [39:24] row_index
  input  logic [im2col_pkg::IN_TDATA_W-1:0]     in_tdata,
  // descriptor output
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  // [5:0] tap_index, [41:6] src_offset, [73:42] dest_offset,
  // [89:74] gap_count, [95:90] zero
  output logic [im2col_pkg::OUT_TDATA_W-1:0]    out_tdata,
  // [0] zero_fill
  output logic [im2col_pkg::OUT_TUSER_W-1:0]    out_tuser,
  output logic                                  out_tlast   // is_last
);
  import im2col_pkg::*;

  cfg_t   cfg;
  issue_t issue;
  logic   adv;
  logic   in_accept;

  // a beat is taken when the sequencer is idle
  assign in_accept = in_tvalid && in_tready;

  im2col_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // tap walk: ky outer, kx inner
  im2col_ctrl #(
    .MAX_KERNEL_SIDE (MAX_KERNEL_SIDE)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .adv       (adv),
    .issue     (issue)
  );

  // offsets, padding test, saturation, output register
  im2col_dp #(
    .MAX_KERNEL_SIDE (MAX_KERNEL_SIDE),
    .COORD_BITS      (COORD_BITS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .in_accept  (in_accept),
    .in_tdata   (in_tdata),
    .issue      (issue),
    .adv        (adv),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

[tb/im2col_patch_descriptor_gen_core_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// im2col_patch_descriptor_gen_core_tb
// Self-checking bench for the im2col descriptor core. Pixels go in as stream
// beats, and each descriptor beat is checked against a model of the tap walk,
// offsets, padding and gap count kept here. Geometry changes only while idle.
// ----------------------------------------------------------------------------
module im2col_patch_descriptor_gen_core_tb;
  import im2col_pkg::*;

  localparam int  MAX_SIDE        = 8;
  localparam int  COORD_W         = 12;
  localparam int  HOLD_OFF_CYCLES = 400;   // one long output stall
  localparam int  STALL_LIMIT     = 4000;  // cycles with no beat at all
  localparam int  DRAIN_CYCLES    = 12;    // pipe depth plus margin
  localparam int  RANDOM_PIXELS   = 290;
  localparam longint SRC_SAT      = 64'h0000_000F_FFFF_FFFF;
  localparam longint DST_SAT      = 64'h0000_0000_FFFF_FFFF;

  // one copy descriptor as seen on the output stream
  typedef struct packed {
    logic [5:0]  tap_index;
    logic [35:0] src_offset;
    logic [31:0] dest_offset;
    logic        zero_fill;
    logic [15:0] gap_count;
    logic        is_last;
  } patch_desc_t;

  // --------------------------------------------------------------------------
  // Scoreboard: shadow copy of the geometry, queue of descriptors still owed.
  // --------------------------------------------------------------------------
  class patch_scoreboard;
    cfg_t        geom;
    patch_desc_t expected_desc[$];
    int          mismatches;

    function new();
      geom = '0;
      geom.src_height   = 13'd1;
      geom.src_width    = 13'd1;
      geom.src_channels = 13'd1;
      geom.row_pitch    = 16'd1;
      mismatches        = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
      case (idx)
        REG_SRC_HEIGHT:    geom.src_height    = value[12:0];
        REG_SRC_WIDTH:     geom.src_width     = value[12:0];
        REG_SRC_CHANNELS:  geom.src_channels  = value[12:0];
        REG_KERNEL_DIMS:   geom.kernel_dims   = value[5:0];
        REG_STRIDE_PAIR:   geom.stride_pair   = value[7:0];
        REG_DILATION_PAIR: geom.dilation_pair = value[7:0];
        REG_PAD_PAIR:      geom.pad_pair      = value[7:0];
        REG_ROW_PITCH:     geom.row_pitch     = value[15:0];
        default: ;
      endcase
    endfunction

    // walk the kernel taps of one accepted pixel and queue their descriptors
    function void note_pixel(logic [11:0] oy, logic [11:0] ox, logic [15:0] row);
      longint kh, kw, sh, sw, dh, dw, pt, pl, hh, ww, cc;
      longint taps, patch, gap, base, sy, sx, tap, soff, doff;
      logic   pad;
      patch_desc_t d;
      kh = longint'(geom.kernel_dims[5:3]) + 1;
      kw = longint'(geom.kernel_dims[2:0]) + 1;
      if (kh > MAX_SIDE) kh = MAX_SIDE;
      if (kw > MAX_SIDE) kw = MAX_SIDE;
      sh = longint'(geom.stride_pair[7:4]) + 1;
      sw = longint'(geom.stride_pair[3:0]) + 1;
      dh = longint'(geom.dilation_pair[7:4]) + 1;
      dw = longint'(geom.dilation_pair[3:0]) + 1;
      pt = longint'(geom.pad_pair[7:4]);
      pl = longint'(geom.pad_pair[3:0]);
      hh = longint'(geom.src_height);
      ww = longint'(geom.src_width);
      cc = longint'(geom.src_channels);
      taps  = kh * kw;
      patch = taps * cc;
      gap   = (longint'(geom.row_pitch) > patch) ? longint'(geom.row_pitch) - patch : 0;
      base  = longint'(row) * longint'(geom.row_pitch);
      for (int ky = 0; ky < kh; ky++) begin
        sy = longint'(oy) * sh + ky * dh - pt;
        for (int kx = 0; kx < kw; kx++) begin
          sx   = longint'(ox) * sw + kx * dw - pl;
          tap  = ky * kw + kx;
          pad  = (sy < 0) || (sy >= hh) || (sx < 0) || (sx >= ww);
          soff = 0;
          if (!pad) begin
            soff = (sy * ww + sx) * cc;
            if (soff > SRC_SAT) soff = SRC_SAT;
          end
          doff = base + tap * cc;
          if (doff > DST_SAT) doff = DST_SAT;
          d.tap_index   = tap[5:0];
          d.src_offset  = soff[35:0];
          d.dest_offset = doff[31:0];
          d.zero_fill   = pad;
          d.is_last     = (tap + 1 == taps);
          d.gap_count   = d.is_last ? gap[15:0] : 16'd0;
          expected_desc.push_back(d);
        end
      end
    endfunction

    function void check_descriptor(logic [OUT_TDATA_W-1:0] tdata,
                                   logic [OUT_TUSER_W-1:0] tuser, logic tlast);
      patch_desc_t got, want;
      got.tap_index   = tdata[5:0];
      got.src_offset  = tdata[41:6];
      got.dest_offset = tdata[73:42];
      got.gap_count   = tdata[89:74];
      got.zero_fill   = tuser[0];
      got.is_last     = tlast;
      if (expected_desc.size() == 0) begin
        if (mismatches < 10)
          $display("[%0t] unexpected descriptor: tap %0d src %0h dst %0h zf %0b gap %0d last %0b",
                   $realtime, got.tap_index, got.src_offset, got.dest_offset,
                   got.zero_fill, got.gap_count, got.is_last);
        mismatches++;
        return;
      end
      want = expected_desc.pop_front();
      if (got !== want) begin
        if (mismatches < 10) begin
          $display("[%0t] descriptor mismatch", $realtime);
          $display("  exp: tap %0d src %0h dst %0h zf %0b gap %0d last %0b",
                   want.tap_index, want.src_offset, want.dest_offset,
                   want.zero_fill, want.gap_count, want.is_last);
          $display("  got: tap %0d src %0h dst %0h zf %0b gap %0d last %0b",
                   got.tap_index, got.src_offset, got.dest_offset,
                   got.zero_fill, got.gap_count, got.is_last);
        end
        mismatches++;
      end
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // DUT signals and instance
  // --------------------------------------------------------------------------
  logic                   clk;
  logic                   rst_n;
  logic                   cfg_wr_en;
  logic [CFG_IDX_W-1:0]   cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_wdata;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;    // [11:0] out_y, [23:12] out_x, [39:24] row_index
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;   // [5:0] tap, [41:6] src, [73:42] dest, [89:74] gap
  logic [OUT_TUSER_W-1:0] out_tuser;   // [0] zero_fill
  logic                   out_tlast;   // is_last

  patch_scoreboard sb;
  bit              hold_off_req;       // main asks the receiver for one long stall

  im2col_patch_descriptor_gen_core #(
    .MAX_KERNEL_SIDE (MAX_SIDE),
    .COORD_BITS      (COORD_W)
  ) u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Driver tasks. Everything is driven with NBAs right after the rising edge,
  // and handshakes are sampled right after the edge too, so both see the
  // values that were live at the edge.
  // --------------------------------------------------------------------------
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] value);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    sb.set_reg(idx, value);
  endtask

  task automatic write_geometry(input logic [15:0] h, input logic [15:0] w,
                                input logic [15:0] c, input logic [15:0] kdims,
                                input logic [15:0] stride, input logic [15:0] dil,
                                input logic [15:0] pad, input logic [15:0] pitch);
    write_reg(REG_SRC_HEIGHT, h);
    write_reg(REG_SRC_WIDTH, w);
    write_reg(REG_SRC_CHANNELS, c);
    write_reg(REG_KERNEL_DIMS, kdims);
    write_reg(REG_STRIDE_PAIR, stride);
    write_reg(REG_DILATION_PAIR, dil);
    write_reg(REG_PAD_PAIR, pad);
    write_reg(REG_ROW_PITCH, pitch);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
  endtask

  // present one pixel and hold it until the core takes the beat
  task automatic send_pixel(input logic [11:0] oy, input logic [11:0] ox,
                            input logic [15:0] row);
    in_tvalid <= 1'b1;
    in_tdata  <= {row, ox, oy};
    do @(posedge clk); while (!in_tready);
    sb.note_pixel(oy, ox, row);
  endtask

  task automatic pause_sender(input int cycles);
    if (cycles > 0) begin
      in_tvalid <= 1'b0;
      repeat (cycles) @(posedge clk);
    end
  endtask

  // everything owed has come out, then let the pipe settle
  task automatic wait_drain();
    while (sb.expected_desc.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // a coordinate that mostly lands inside the image, sometimes anywhere
  function automatic logic [11:0] pick_coord(longint extent, longint pad, longint stride);
    longint hi;
    int     r;
    r = $urandom_range(0, 9);
    if (r < 7) begin
      hi = (extent + pad) / stride + 1;
      if (hi > 4095) hi = 4095;
      return 12'($urandom_range(0, int'(hi)));
    end
    if (r == 7) return 12'd0;
    if (r == 8) return 12'hFFF;
    return 12'($urandom);
  endfunction

  function automatic logic [15:0] pick_size13();
    case ($urandom_range(0, 7))
      0:       return 16'd0;
      1:       return 16'd8191;
      2:       return 16'($urandom);            // upper bits are don't-care
      default: return 16'($urandom_range(1, 40));
    endcase
  endfunction

  function automatic logic [15:0] pick_pair();
    if ($urandom_range(0, 1)) return 16'($urandom_range(0, 255));
    return {8'd0, 3'd0, 1'($urandom_range(0, 1)), 3'd0, 1'($urandom_range(0, 1))};
  endfunction

  task automatic random_geometry();
    logic [15:0] h, w, c, k, pitch;
    longint      patch;
    h = pick_size13();
    w = pick_size13();
    c = pick_size13();
    // big kernels are slow; keep most of them small
    if ($urandom_range(0, 1)) k = 16'($urandom_range(0, 63));
    else k = {10'd0, 3'($urandom_range(0, 2)), 3'($urandom_range(0, 2))};
    patch = (longint'(k[5:3]) + 1) * (longint'(k[2:0]) + 1) * longint'(c[12:0]);
    case ($urandom_range(0, 5))
      0:       pitch = 16'd0;
      1:       pitch = 16'hFFFF;
      2, 3:    pitch = 16'($urandom);
      default: pitch = (patch + 64 > 65535) ? 16'hFFFF : 16'(patch + $urandom_range(0, 64));
    endcase
    write_geometry(h, w, c, k, pick_pair(), pick_pair(), pick_pair(), pitch);
  endtask

  // random pixels in bursts; no_gaps keeps tvalid up the whole time
  task automatic send_random_pixels(input int count, input bit no_gaps);
    int          burst_left;
    logic [11:0] oy, ox;
    logic [15:0] row;
    burst_left = 0;
    for (int i = 0; i < count; i++) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 12);
        if (!no_gaps && $urandom_range(0, 3) != 0) pause_sender($urandom_range(1, 25));
      end
      oy = pick_coord(longint'(sb.geom.src_height), longint'(sb.geom.pad_pair[7:4]),
                      longint'(sb.geom.stride_pair[7:4]) + 1);
      ox = pick_coord(longint'(sb.geom.src_width), longint'(sb.geom.pad_pair[3:0]),
                      longint'(sb.geom.stride_pair[3:0]) + 1);
      case ($urandom_range(0, 7))
        0:       row = 16'd0;
        1:       row = 16'hFFFF;
        default: row = 16'($urandom);
      endcase
      send_pixel(oy, ox, row);
      burst_left--;
    end
    in_tvalid <= 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Receiver: tready pattern is picked anew at random intervals (always ready,
  // coin flip, mostly ready, periodic), plus one long hold-off on request.
  // --------------------------------------------------------------------------
  initial begin : receiver
    int mode, left;
    out_tready <= 1'b0;
    mode = 0;
    left = 0;
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        out_tready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
        hold_off_req = 1'b0;
      end else begin
        if (left == 0) begin
          mode = $urandom_range(0, 3);
          left = $urandom_range(20, 120);
        end
        left--;
        case (mode)
          0:       out_tready <= 1'b1;
          1:       out_tready <= 1'($urandom_range(0, 1));
          2:       out_tready <= ($urandom_range(0, 3) != 0);
          default: out_tready <= ((left % 5) < 2);
        endcase
      end
    end
  end

  // output monitor
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      sb.check_descriptor(out_tdata, out_tuser, out_tlast);
  end

  // watchdog: too long without a beat on either stream ends the run
  initial begin : watchdog
    int stuck;
    stuck = 0;
    while (stuck < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) stuck = 0;
      else stuck++;
    end
    $display("CHECKS FAILED");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin : main
    int sent;
    sb = new();
    hold_off_req = 1'b0;
    rst_n     <= 1'b0;
    cfg_wr_en <= 1'b0;
    cfg_index <= '0;
    cfg_wdata <= '0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset geometry: 1x1 image, 1x1 kernel; the off-image pixels pad
    send_pixel(12'd0, 12'd0, 16'd0);
    send_pixel(12'd1, 12'd2, 16'd7);
    send_pixel(12'hFFF, 12'hFFF, 16'hFFFF);
    in_tvalid <= 1'b0;
    wait_drain();

    // 5x6x3 image, 3x3 kernel, pad 1: corners and interior
    write_geometry(16'd5, 16'd6, 16'd3, 16'o22, 16'h00, 16'h00, 16'h11, 16'd40);
    send_pixel(12'd0, 12'd0, 16'd0);
    send_pixel(12'd4, 12'd5, 16'd1);
    send_pixel(12'd2, 12'd3, 16'd2);
    send_pixel(12'd0, 12'd5, 16'd3);
    in_tvalid <= 1'b0;
    wait_drain();

    // pad 2 with a 3x3 kernel: whole kernel rows in padding; pitch == patch
    write_geometry(16'd4, 16'd4, 16'd2, 16'o22, 16'h00, 16'h00, 16'h22, 16'd18);
    send_pixel(12'd0, 12'd0, 16'd9);
    send_pixel(12'd3, 12'd3, 16'd10);
    in_tvalid <= 1'b0;
    wait_drain();

    // everything at max: offsets saturate, pitch below patch gives no gap
    write_geometry(16'd8191, 16'd8191, 16'd8191, 16'd63, 16'hFF, 16'hFF, 16'hFF, 16'hFFFF);
    send_pixel(12'hFFF, 12'hFFF, 16'hFFFF);
    send_pixel(12'd0, 12'd0, 16'd0);
    send_pixel(12'd2048, 12'd100, 16'd1);
    in_tvalid <= 1'b0;
    wait_drain();

    // empty image and no channels: all taps pad, all offsets zero
    write_geometry(16'd0, 16'd0, 16'd0, 16'o11, 16'h00, 16'h00, 16'h00, 16'd0);
    send_pixel(12'd0, 12'd0, 16'd0);
    send_pixel(12'd3, 12'd9, 16'hFFFF);
    in_tvalid <= 1'b0;
    wait_drain();

    // single tap, one channel, huge pitch: large gap count
    write_geometry(16'd16, 16'd16, 16'd1, 16'd0, 16'h11, 16'h00, 16'h00, 16'hFFFF);
    send_pixel(12'd1, 12'd1, 16'd0);
    send_pixel(12'd15, 12'd15, 16'hFFFF);
    in_tvalid <= 1'b0;
    wait_drain();

    // back-pressure: receiver holds off while pixels keep coming back to back
    write_geometry(16'd12, 16'd12, 16'd4, 16'o22, 16'h00, 16'h11, 16'h11, 16'd64);
    hold_off_req = 1'b1;
    send_random_pixels(40, 1'b1);
    wait_drain();
    sent = 40;

    // random geometry phases
    while (sent < RANDOM_PIXELS) begin
      int n;
      n = $urandom_range(15, 40);
      random_geometry();
      send_random_pixels(n, $urandom_range(0, 4) == 0);
      wait_drain();
      sent += n;
    end

    if (sb.mismatches == 0 && sb.expected_desc.size() == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule

[im2col_patch_descriptor_gen_core.f]
rtl/core/im2col_pkg.sv
rtl/core/im2col_cfg.sv
rtl/core/im2col_ctrl.sv
rtl/core/im2col_dp.sv
rtl/core/im2col_patch_descriptor_gen_core.sv
tb/im2col_patch_descriptor_gen_core_tb.sv
